// File: hdl/cfbda_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the circular FIFO with batch dequeue.
// No dependencies; imported by the top level.

package cfbda_pkg;

    // Ring buffer geometry
    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int DATA_W  = 32;
    localparam int BATCH_W = 8;
    localparam int SUM_W   = 36;
    localparam int AVG_W   = 40;
    localparam int CMP_W   = (OCC_W > BATCH_W) ? OCC_W : BATCH_W;

    // Stream packing
    localparam int IN_TDATA_W  = ((DATA_W + BATCH_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - DATA_W - BATCH_W;
    localparam int OUT_FIELD_W = DATA_W + CNT_W + SUM_W + AVG_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Average divider: magnitude of sum scaled by 256, four quotient bits a cycle
    localparam int FRAC_W     = 8;
    localparam int DIVD_W     = SUM_W + FRAC_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = DIVD_W / DIV_STEP;
    localparam int DIVC_W     = $clog2(DIV_CYCLES + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DISPLAY = 2'd2,
        OP_PEEK    = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_STORED  = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_REMOVED = 3'd3,
        STAT_LISTED  = 3'd4,
        STAT_FRONT   = 3'd5
    } status_t;

    // Advance a ring index with wrap at DEPTH
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

endpackage

// File: hdl/cfbda_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds while read enable is low.

module cfbda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/circular_fifo_batch_dequeue_average_unit.sv
`timescale 1ns / 1ps
// Top level of the circular FIFO with batch dequeue and Q8 average.
// Depends on cfbda_pkg and cfbda_ram.
//
// Usage: requests enter on the s_axis channel (tuser = opcode, tdata = value and
// batch count) and results leave on the m_axis channel (tuser = status, tlast
// marks the final result of a request). Requests are taken one at a time: the
// input is ready only while no request is in progress.
// Steps per request:
//   enqueue, or any request on an empty buffer: one result.
//   peek: one storage RAM read and one result. display of n words: each word
//   costing one storage RAM read and one result slot.
//   dequeue of n words: one storage RAM read per word, then the four-bits-a-
//   cycle divider forms the rounded Q8 average, and a final state loads the
//   final result.
// A dequeue with batch count zero on a non-empty buffer gives no result.
// Reset empties the buffer (head, tail and occupancy cleared); storage words are
// not cleared and are only read after being written. A stalled receiver holds
// the output register, and the sequencer waits before loading the next result.

module circular_fifo_batch_dequeue_average_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cfbda_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_value, batch_count
    input  logic [cfbda_pkg::OP_W-1:0]          s_axis_tuser,  // opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cfbda_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // out_value, removed_total,
                                                               // removed_sum, average_q8
    output logic [cfbda_pkg::STAT_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast   // last
);

    import cfbda_pkg::*;

    localparam int CHK_W = OCC_W + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_DATA   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    opcode_t                    op_reg, op_next;
    logic [DATA_W-1:0]          data_reg, data_next;
    logic [BATCH_W-1:0]         batch_reg, batch_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           tail_reg, tail_next;
    logic [OCC_W-1:0]           occ_reg, occ_next;
    logic [IDX_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           todo_reg, todo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [DATA_W-1:0]          val_reg, val_next;
    logic                       neg_reg, neg_next;
    logic [DIVD_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [DIVC_W-1:0]          div_cnt_reg, div_cnt_next;

    logic                       out_valid_reg, out_valid_next;
    status_t                    out_status_reg, out_status_next;
    logic [DATA_W-1:0]          out_value_reg, out_value_next;
    logic [CNT_W-1:0]           out_total_reg, out_total_next;
    logic [SUM_W-1:0]           out_sum_reg, out_sum_next;
    logic [AVG_W-1:0]           out_avg_reg, out_avg_next;
    logic                       out_last_reg, out_last_next;

    logic                       emit;
    logic                       out_free;
    logic                       ram_we;
    logic                       ram_re;
    logic [DATA_W-1:0]          ram_rdata;

    logic [CMP_W-1:0]           lim;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       fin;
    logic [SUM_W-1:0]           sum_add;
    logic [SUM_W-1:0]           mag;
    logic [DIVD_W-1:0]          step_quo;
    logic [CNT_W-1:0]           step_rem;
    logic [CNT_W:0]             trial;
    logic [AVG_W-1:0]           avg_mag;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Storage ring
    cfbda_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_storage (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Clamp the number of results for a request
    always_comb
    begin
        if ((op_reg == OP_DEQUEUE) && (CMP_W'(batch_reg) < CMP_W'(occ_reg)))
        begin
            lim = CMP_W'(batch_reg);
        end
        else
        begin
            lim = CMP_W'(occ_reg);
        end
        if (lim > CMP_W'(MAX_RESULTS))
        begin
            lim = CMP_W'(MAX_RESULTS);
        end
    end

    assign cnt_inc = cnt_reg + 1'b1;
    assign fin     = (cnt_inc == todo_reg);
    assign sum_add = sum_reg + SUM_W'($signed(ram_rdata));
    assign mag     = sum_add[SUM_W-1] ? (SUM_W'(0) - sum_add) : sum_add;
    assign avg_mag = quo_reg[AVG_W-1:0];

    // Divider step: four restoring compare-and-subtract steps per cycle
    always_comb
    begin
        step_quo = quo_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial    = {step_rem, step_quo[DIVD_W-1]};
            step_quo = {step_quo[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, cnt_reg})
            begin
                step_rem    = CNT_W'(trial - {1'b0, cnt_reg});
                step_quo[0] = 1'b1;
            end
            else
            begin
                step_rem = trial[CNT_W-1:0];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        data_next       = data_reg;
        batch_next      = batch_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        rd_ptr_next     = rd_ptr_reg;
        todo_next       = todo_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        val_next        = val_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        emit            = 1'b0;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_total_next  = '0;
        out_sum_next    = '0;
        out_avg_next    = '0;
        out_last_next   = 1'b1;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = opcode_t'(s_axis_tuser);
                    data_next  = s_axis_tdata[DATA_W-1:0];
                    batch_next = s_axis_tdata[DATA_W +: BATCH_W];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (op_reg == OP_ENQUEUE)
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        out_value_next = data_reg;
                        if (occ_reg == OCC_W'(DEPTH))
                        begin
                            out_status_next = STAT_FULL;
                        end
                        else
                        begin
                            out_status_next = STAT_STORED;
                            ram_we          = 1'b1;
                            tail_next       = next_idx(tail_reg);
                            occ_next        = occ_reg + 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (occ_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit            = 1'b1;
                        out_status_next = STAT_EMPTY;
                        out_value_next  = '0;
                        state_next      = S_IDLE;
                    end
                end
                else if ((op_reg == OP_DEQUEUE) && (batch_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    todo_next   = (op_reg == OP_PEEK) ? CNT_W'(1) : CNT_W'(lim);
                    cnt_next    = '0;
                    sum_next    = '0;
                    rd_ptr_next = head_reg;
                    state_next  = S_READ;
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_DATA;
            end

            S_DATA:
            begin
                case (op_reg)
                    OP_DEQUEUE:
                    begin
                        if (fin)
                        begin
                            // Remove the last word and start the average
                            head_next    = next_idx(head_reg);
                            occ_next     = occ_reg - 1'b1;
                            cnt_next     = cnt_inc;
                            sum_next     = sum_add;
                            val_next     = ram_rdata;
                            neg_next     = sum_add[SUM_W-1];
                            quo_next     = {mag, FRAC_W'(0)} + DIVD_W'(cnt_inc >> 1);
                            rem_next     = '0;
                            div_cnt_next = '0;
                            state_next   = S_DIV;
                        end
                        else if (out_free)
                        begin
                            emit            = 1'b1;
                            out_status_next = STAT_REMOVED;
                            out_value_next  = ram_rdata;
                            out_total_next  = cnt_inc;
                            out_sum_next    = sum_add;
                            out_last_next   = 1'b0;
                            head_next       = next_idx(head_reg);
                            occ_next        = occ_reg - 1'b1;
                            cnt_next        = cnt_inc;
                            sum_next        = sum_add;
                            rd_ptr_next     = next_idx(rd_ptr_reg);
                            state_next      = S_READ;
                        end
                    end
                    OP_DISPLAY:
                    begin
                        if (out_free)
                        begin
                            emit            = 1'b1;
                            out_status_next = STAT_LISTED;
                            out_value_next  = ram_rdata;
                            out_last_next   = fin;
                            cnt_next        = cnt_inc;
                            rd_ptr_next     = next_idx(rd_ptr_reg);
                            state_next      = fin ? S_IDLE : S_READ;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit            = 1'b1;
                            out_status_next = STAT_FRONT;
                            out_value_next  = ram_rdata;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                quo_next     = step_quo;
                rem_next     = step_rem;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIVC_W'(DIV_CYCLES - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    out_status_next = STAT_REMOVED;
                    out_value_next  = val_reg;
                    out_total_next  = cnt_reg;
                    out_sum_next    = sum_reg;
                    out_avg_next    = neg_reg ? (AVG_W'(0) - avg_mag) : avg_mag;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        data_reg   <= data_next;
        batch_reg  <= batch_next;
        rd_ptr_reg <= rd_ptr_next;
        todo_reg   <= todo_next;
        cnt_reg    <= cnt_next;
        sum_reg    <= sum_next;
        val_reg    <= val_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_total_reg  <= out_total_next;
            out_sum_reg    <= out_sum_next;
            out_avg_reg    <= out_avg_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_avg_reg, out_sum_reg, out_total_reg,
                            out_value_reg};

    // Occupancy never exceeds the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    // Tail stays occupancy entries ahead of head, modulo depth
    assert property (@(posedge clk) disable iff (!rst_n)
        ((CHK_W'(head_reg) + CHK_W'(occ_reg)) == CHK_W'(tail_reg)) ||
        ((CHK_W'(head_reg) + CHK_W'(occ_reg)) == (CHK_W'(tail_reg) + CHK_W'(DEPTH))))
        else $error("head, tail and occupancy disagree");

    // Only removal results carry a batch count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STAT_REMOVED)) |-> (out_total_reg == '0))
        else $error("batch count on a non-removal result");

endmodule
